// File: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int SLOT_W   = 3;
  localparam int CORE_W   = 10;
  localparam int RAM_W    = 20;
  localparam int TOTAL_W  = 13;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [CORE_W-1:0]  CORE_MAX  = '1;
  localparam logic [RAM_W-1:0]   RAM_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_IDLE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd3;

  // One transaction as it walks from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic [CORE_W-1:0] cores;
    logic [RAM_W-1:0]  ram;
    logic              granted;
    logic [SLOT_W-1:0] chosen;
  } token_t;

endpackage

// File: rtl/first_fit_core_ram_allocator_top.sv
// Channel   Handshake             Ports
// input     start & !busy         in_func, in_slot_index, in_core_count, in_ram_mib
// result    out_strobe (1 cycle)  out_status, out_chosen_slot, out_idle_total
//
// A request made while no cores are idle is answered in the cycle after it is taken.
// Every other transaction walks the chain of slot cells, one cell per cycle, and its
// result is registered once it leaves the last cell; busy is high until then.
// A new transaction may be taken in the cycle its predecessor's result is shown.
// Synchronous active-low reset empties every slot and the idle total.
// The receiver cannot stall: each result is valid for exactly one cycle.
module first_fit_core_ram_allocator_top #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffa_pkg::FUNC_W-1:0]    in_func,
  input  logic [ffa_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [ffa_pkg::CORE_W-1:0]    in_core_count,
  input  logic [ffa_pkg::RAM_W-1:0]     in_ram_mib,
  output logic                          out_strobe,
  output logic [ffa_pkg::STATUS_W-1:0]  out_status,
  output logic [ffa_pkg::SLOT_W-1:0]    out_chosen_slot,
  output logic [ffa_pkg::TOTAL_W-1:0]   out_idle_total
);

  localparam logic [6:0] SLOT_LIMIT = 7'(SLOT_COUNT);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                        state_r, state_nxt;
  ffa_pkg::token_t               tok_r, tok_nxt;
  logic                          strobe_r, strobe_nxt;
  logic [ffa_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [ffa_pkg::SLOT_W-1:0]    chosen_r, chosen_nxt;
  logic [ffa_pkg::TOTAL_W-1:0]   total_r, total_nxt;

  ffa_pkg::token_t               tok_chain [SLOT_COUNT+1];
  logic [SLOT_COUNT:0]           tok_valid;
  ffa_pkg::token_t               tok_end;
  logic                          in_range;
  logic [ffa_pkg::TOTAL_W:0]     total_sum;

  assign tok_chain[0] = tok_r;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ffa_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (tok_chain[i]),
      .tok_out(tok_chain[i+1])
    );
  end

  for (genvar i = 0; i <= SLOT_COUNT; i++) begin : g_valid
    assign tok_valid[i] = tok_chain[i].valid;
  end

  assign tok_end   = tok_chain[SLOT_COUNT];
  assign in_range  = ({4'b0, tok_end.slot} < SLOT_LIMIT);
  assign total_sum = {1'b0, total_r} + {4'b0, tok_end.cores};

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    tok_nxt.valid = 1'b0;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    chosen_nxt    = chosen_r;
    total_nxt     = total_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == ffa_pkg::FUNC_REQUEST && total_r == '0) begin
            strobe_nxt = 1'b1;
            status_nxt = ffa_pkg::STATUS_NO_IDLE;
            chosen_nxt = '0;
          end else begin
            tok_nxt.valid   = 1'b1;
            tok_nxt.func    = in_func;
            tok_nxt.slot    = in_slot_index;
            tok_nxt.cores   = in_core_count;
            tok_nxt.ram     = in_ram_mib;
            tok_nxt.granted = 1'b0;
            tok_nxt.chosen  = '0;
            state_nxt       = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (tok_end.valid) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
          chosen_nxt = '0;
          status_nxt = ffa_pkg::STATUS_DONE;
          if (tok_end.func == ffa_pkg::FUNC_REQUEST) begin
            if (tok_end.granted) begin
              status_nxt = ffa_pkg::STATUS_GRANTED;
              chosen_nxt = tok_end.chosen;
              total_nxt  = ({3'b0, tok_end.cores} > total_r) ? '0 :
                           total_r - {3'b0, tok_end.cores};
            end else begin
              status_nxt = ffa_pkg::STATUS_NO_FIT;
            end
          end else if ((tok_end.func == ffa_pkg::FUNC_RELEASE ||
                        tok_end.func == ffa_pkg::FUNC_LOAD) && in_range) begin
            total_nxt = total_sum[ffa_pkg::TOTAL_W] ? ffa_pkg::TOTAL_MAX :
                        total_sum[ffa_pkg::TOTAL_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tok_r.valid <= 1'b0;
      strobe_r    <= 1'b0;
      status_r    <= ffa_pkg::STATUS_DONE;
      chosen_r    <= '0;
      total_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      tok_r    <= tok_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
      chosen_r <= chosen_nxt;
      total_r  <= total_nxt;
    end
  end

  assign busy            = (state_r == S_WALK);
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_chosen_slot = chosen_r;
  assign out_idle_total  = total_r;

`ifndef SYNTHESIS
  // Only one transaction is ever in flight along the chain.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid))
    else $error("more than one transaction in the slot chain");

  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ffa_pkg::STATUS_GRANTED) |->
      ({4'b0, out_chosen_slot} < SLOT_LIMIT))
    else $error("granted slot beyond the slot count");

  a_no_idle_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ffa_pkg::STATUS_NO_IDLE) |->
      (out_idle_total == '0 && out_chosen_slot == '0))
    else $error("refusal for no idle cores with a non-zero total");

  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_func == ffa_pkg::FUNC_REQUEST && out_idle_total == '0)) |=>
      (busy && tok_valid[0]))
    else $error("accepted transaction did not enter the chain");
`endif

endmodule

// File: rtl/ffa_cell.sv
module ffa_cell #(
  parameter int CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ffa_pkg::token_t tok_in,
  output ffa_pkg::token_t tok_out
);

  localparam logic [ffa_pkg::SLOT_W-1:0] ID_LOW    = ffa_pkg::SLOT_W'(CELL_ID % 8);
  localparam logic                       ADDRESSED = (CELL_ID < 8);

  logic [ffa_pkg::CORE_W-1:0] free_cores_r, free_cores_nxt;
  logic [ffa_pkg::RAM_W-1:0]  free_ram_r, free_ram_nxt;
  ffa_pkg::token_t            tok_r, tok_nxt;

  logic                       fits;
  logic                       hit;
  logic [ffa_pkg::CORE_W:0]   core_sum;
  logic [ffa_pkg::RAM_W:0]    ram_sum;

  assign fits = !tok_in.granted && (tok_in.cores <= free_cores_r) &&
                (tok_in.ram <= free_ram_r);
  assign hit  = ADDRESSED && (tok_in.slot == ID_LOW);
  assign core_sum = {1'b0, free_cores_r} + {1'b0, tok_in.cores};
  assign ram_sum  = {1'b0, free_ram_r} + {1'b0, tok_in.ram};

  always_comb begin
    free_cores_nxt = free_cores_r;
    free_ram_nxt   = free_ram_r;
    tok_nxt        = tok_in;
    if (tok_in.valid) begin
      unique case (tok_in.func)
        ffa_pkg::FUNC_REQUEST: begin
          if (fits) begin
            free_cores_nxt  = free_cores_r - tok_in.cores;
            free_ram_nxt    = free_ram_r - tok_in.ram;
            tok_nxt.granted = 1'b1;
            tok_nxt.chosen  = ID_LOW;
          end
        end
        ffa_pkg::FUNC_RELEASE: begin
          if (hit) begin
            free_cores_nxt = core_sum[ffa_pkg::CORE_W] ? ffa_pkg::CORE_MAX :
                             core_sum[ffa_pkg::CORE_W-1:0];
            free_ram_nxt   = ram_sum[ffa_pkg::RAM_W] ? ffa_pkg::RAM_MAX :
                             ram_sum[ffa_pkg::RAM_W-1:0];
          end
        end
        ffa_pkg::FUNC_LOAD: begin
          if (hit) begin
            free_cores_nxt = tok_in.cores;
            free_ram_nxt   = tok_in.ram;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cores_r <= '0;
      free_ram_r   <= '0;
      tok_r.valid  <= 1'b0;
    end else begin
      free_cores_r <= free_cores_nxt;
      free_ram_r   <= free_ram_nxt;
      tok_r        <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: tb/first_fit_core_ram_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_core_ram_allocator_top_tb;

  typedef logic [ffa_pkg::FUNC_W-1:0]   func_t;
  typedef logic [ffa_pkg::SLOT_W-1:0]   slot_t;
  typedef logic [ffa_pkg::CORE_W-1:0]   core_t;
  typedef logic [ffa_pkg::RAM_W-1:0]    ram_t;
  typedef logic [ffa_pkg::STATUS_W-1:0] status_t;
  typedef logic [ffa_pkg::TOTAL_W-1:0]  total_t;

  localparam int    SLOT_COUNT   = 8;
  localparam int    RANDOM_ITEMS = 1530;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    DRAIN_CYCLES = SLOT_COUNT + 6;
  localparam func_t FUNC_UNUSED  = 2'd3;

  typedef struct packed {
    status_t status;
    slot_t   chosen;
    total_t  total;
  } alloc_outcome_t;

  // Tracks the free counts of every slot and the queue of answers still due.
  class alloc_scoreboard;
    core_t          free_cores [SLOT_COUNT];
    ram_t           free_ram [SLOT_COUNT];
    total_t         idle_total;
    alloc_outcome_t answers_due[$];
    int             mismatches;
    int             status_seen [4];

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        free_cores[i] = '0;
        free_ram[i]   = '0;
      end
      idle_total = '0;
      mismatches = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    function total_t total_plus(input core_t c);
      int unsigned sum;
      sum = idle_total + c;
      return (sum > ffa_pkg::TOTAL_MAX) ? ffa_pkg::TOTAL_MAX : sum[ffa_pkg::TOTAL_W-1:0];
    endfunction

    function void note_input(input func_t f, input slot_t s, input core_t c, input ram_t r);
      alloc_outcome_t o;
      int unsigned    sum;
      o.status = ffa_pkg::STATUS_DONE;
      o.chosen = '0;
      if (f == ffa_pkg::FUNC_REQUEST) begin
        if (idle_total == 0) begin
          o.status = ffa_pkg::STATUS_NO_IDLE;
        end else begin
          o.status = ffa_pkg::STATUS_NO_FIT;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (c <= free_cores[i] && r <= free_ram[i]) begin
              free_cores[i] = free_cores[i] - c;
              free_ram[i]   = free_ram[i] - r;
              idle_total    = (c > idle_total) ? '0 : idle_total - c;
              o.status      = ffa_pkg::STATUS_GRANTED;
              o.chosen      = i[ffa_pkg::SLOT_W-1:0];
              break;
            end
          end
        end
      end else if (f == ffa_pkg::FUNC_RELEASE) begin
        if (s < SLOT_COUNT) begin
          sum = free_cores[s] + c;
          free_cores[s] = (sum > ffa_pkg::CORE_MAX) ? ffa_pkg::CORE_MAX :
                          sum[ffa_pkg::CORE_W-1:0];
          sum = free_ram[s] + r;
          free_ram[s] = (sum > ffa_pkg::RAM_MAX) ? ffa_pkg::RAM_MAX : sum[ffa_pkg::RAM_W-1:0];
          idle_total = total_plus(c);
        end
      end else if (f == ffa_pkg::FUNC_LOAD) begin
        if (s < SLOT_COUNT) begin
          free_cores[s] = c;
          free_ram[s]   = r;
          idle_total    = total_plus(c);
        end
      end
      o.total = idle_total;
      status_seen[o.status]++;
      answers_due = {answers_due, o};
    endfunction

    function void check_result(input status_t st, input slot_t sl, input total_t tot);
      alloc_outcome_t o;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d total %0d", st, sl, tot);
        return;
      end
      o = answers_due.pop_front();
      if (st !== o.status || sl !== o.chosen || tot !== o.total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected status %0d slot %0d total %0d, got %0d %0d %0d",
                   $realtime, o.status, o.chosen, o.total, st, sl, tot);
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  func_t   in_func;
  slot_t   in_slot_index;
  core_t   in_core_count;
  ram_t    in_ram_mib;
  logic    out_strobe;
  status_t out_status;
  slot_t   out_chosen_slot;
  total_t  out_idle_total;

  alloc_scoreboard sb;
  int              accepted_count = 0;
  int              cycle_count = 0;

  first_fit_core_ram_allocator_top #(.SLOT_COUNT(SLOT_COUNT)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_slot_index   (in_slot_index),
    .in_core_count   (in_core_count),
    .in_ram_mib      (in_ram_mib),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_chosen_slot (out_chosen_slot),
    .out_idle_total  (out_idle_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are checked before the new transaction is noted, both at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_status, out_chosen_slot, out_idle_total);
      if (start && !busy) begin
        sb.note_input(in_func, in_slot_index, in_core_count, in_ram_mib);
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_item(input func_t f, input slot_t s, input core_t c, input ram_t r);
    int taken;
    taken         = accepted_count;
    in_func       = f;
    in_slot_index = s;
    in_core_count = c;
    in_ram_mib    = r;
    start         = 1'b1;
    do @(negedge clk); while (accepted_count == taken);
  endtask

  task automatic pause_until_empty();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random(input bit may_idle);
    func_t f;
    slot_t s;
    core_t c;
    ram_t  r;
    int    pick;
    int    mode;
    if (may_idle && $urandom_range(0, 99) < 7) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    pick = $urandom_range(0, 99);
    mode = $urandom_range(0, 99);
    s    = slot_t'($urandom_range(0, SLOT_COUNT - 1));
    c    = core_t'($urandom);
    r    = ram_t'($urandom);
    if (pick < 40) begin
      f = ffa_pkg::FUNC_REQUEST;
      // Mostly sized against what some slot can still give, so grants stay common.
      if (mode < 15) begin
        c = sb.free_cores[s];
        r = sb.free_ram[s];
      end else if (mode < 65) begin
        c = core_t'($urandom_range(0, sb.free_cores[s]));
        r = ram_t'($urandom_range(0, sb.free_ram[s]));
      end else if (mode < 85) begin
        c = core_t'($urandom_range(0, 63));
        r = ram_t'($urandom_range(0, 4095));
      end
    end else if (pick < 65) begin
      f = ffa_pkg::FUNC_RELEASE;
      if (mode < 80) begin
        c = core_t'($urandom_range(0, 63));
        r = ram_t'($urandom_range(0, 65535));
      end else if (mode < 85) begin
        c = ffa_pkg::CORE_MAX;
        r = ffa_pkg::RAM_MAX;
      end
    end else if (pick < 93) begin
      f = ffa_pkg::FUNC_LOAD;
      if (mode < 10) begin
        c = '0;
        r = '0;
      end else if (mode < 20) begin
        c = ffa_pkg::CORE_MAX;
        r = ffa_pkg::RAM_MAX;
      end
    end else begin
      f = FUNC_UNUSED;
    end
    send_item(f, s, c, r);
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = ffa_pkg::FUNC_REQUEST;
    in_slot_index = '0;
    in_core_count = '0;
    in_ram_mib    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty block, zero-core requests, first-fit order, saturation.
    send_item(ffa_pkg::FUNC_REQUEST, 3'd0, 10'd5, 20'd5);
    send_item(FUNC_UNUSED, '1, ffa_pkg::CORE_MAX, ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_LOAD, 3'd0, '0, '0);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd0, '0, '0);
    send_item(ffa_pkg::FUNC_LOAD, 3'd7, ffa_pkg::CORE_MAX, ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_LOAD, 3'd3, 10'd10, 20'd100);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd5, '0, 20'd50);
    send_item(ffa_pkg::FUNC_REQUEST, '1, '0, '0);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd0, 10'd11, 20'd10);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd0, ffa_pkg::CORE_MAX, ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_RELEASE, 3'd7, ffa_pkg::CORE_MAX, ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd0, ffa_pkg::CORE_MAX, ffa_pkg::RAM_MAX);
    for (int i = 0; i < 8; i++)
      send_item(ffa_pkg::FUNC_RELEASE, i[ffa_pkg::SLOT_W-1:0], ffa_pkg::CORE_MAX,
                ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_LOAD, 3'd1, ffa_pkg::CORE_MAX, '0);
    send_item(ffa_pkg::FUNC_LOAD, 3'd2, '0, ffa_pkg::RAM_MAX);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd2, 10'h2AA, 20'hAAAAA);
    send_item(ffa_pkg::FUNC_REQUEST, 3'd5, 10'h155, 20'h55555);
    pause_until_empty();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) pause_until_empty();
      send_random(!(n >= 600 && n < 1000));
    end
    start = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d transactions: %0d granted, %0d with no fitting slot,",
             accepted_count, sb.status_seen[ffa_pkg::STATUS_GRANTED],
             sb.status_seen[ffa_pkg::STATUS_NO_FIT]);
    $display("%0d with no idle cores, %0d updates; %0d mismatches, %0d answers missing",
             sb.status_seen[ffa_pkg::STATUS_NO_IDLE], sb.status_seen[ffa_pkg::STATUS_DONE],
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
